// ===== design/assert_macros.svh =====
// assertion macros shared by the escape-time pixel design
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jetp_pkg.sv =====
// types, constants and helpers for the julia escape-time pixel block
// no dependencies
package jetp_pkg;

    // fixed point format of z, c, step and origin
    localparam int FRAC_BITS = 28;

    // escape when re^2 + im^2 >= 4 * 2^(2*FRAC_BITS)
    localparam int ESC_BIT = 2 * FRAC_BITS + 2;

    // saturation bounds for the 32-bit component words
    localparam logic signed [43:0] SAT_MAX = 44'sd2147483647;
    localparam logic signed [43:0] SAT_MIN = -44'sd2147483648;

    // register map, word index on the configuration port
    typedef enum logic [2:0] {
        REG_CONST_RE    = 3'd0,
        REG_CONST_IM    = 3'd1,
        REG_PIXEL_STEP  = 3'd2,
        REG_ORIGIN_RE   = 3'd3,
        REG_ORIGIN_IM   = 3'd4,
        REG_ITER_LIMIT  = 3'd5,
        REG_COLOR_BASE  = 3'd6,
        REG_LINE_STRIDE = 3'd7
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_START,
        ST_MUL,
        ST_UPD,
        ST_COLOR,
        ST_RESULT
    } t_state;

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== design/julia_escape_time_pixel.sv =====
// julia set escape-time evaluator for one pixel, top level
// depends on jetp_pkg and assert_macros.svh
//
// usage:
//  input channel (i_in_valid / o_in_stall) carries one pixel word: i_pixel_x,
//  i_pixel_y. the block maps it to z = pixel * pixel_step + origin, then runs
//  z = z^2 + c until |z|^2 >= 4 or the count reaches iteration_limit.
//  output channel (o_out_valid / i_out_stall) returns one result word per
//  pixel: iteration count, inside flag, color and framebuffer byte offset.
//  one complex square unit (three 33x33 multipliers with shared operand
//  selection) does the start point, row offset, iteration and color products.
//  each iteration is a multiply state followed by an update and escape test
//  state, and the first update of z takes one more such pair. the next pixel
//  can be taken in the cycle after the result is loaded; one pixel in flight.
//  o_in_stall is high while a pixel is being evaluated.
//  a finished result sits in an output register; a new pixel may be taken
//  while it waits. a stalled receiver holds the result and, once the next
//  pixel is done too, holds the sequencer until the register frees up.
//  reset (synchronous, active low) loads the register defaults and empties
//  the pipeline. configuration goes through the apb port and is to be written
//  only idle, by the user; the block itself does not enforce it.
`include "assert_macros.svh"

module julia_escape_time_pixel #(
    parameter int BYTES_PER_PIXEL = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // pixel input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,

    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_iteration_count,
    output logic        o_inside_set,
    output logic [31:0] o_pixel_color,
    output logic [23:0] o_byte_offset
);

    // configuration registers
    logic signed [30:0] r_const_re;
    logic signed [30:0] r_const_im;
    logic        [30:0] r_pixel_step;
    logic signed [31:0] r_origin_re;
    logic signed [31:0] r_origin_im;
    logic        [11:0] r_iter_limit;
    logic        [31:0] r_color_base;
    logic        [14:0] r_line_stride;

    // sequencer and datapath registers
    jetp_pkg::t_state   r_state, n_state;
    logic        [9:0]  r_px, n_px;
    logic        [9:0]  r_py, n_py;
    logic signed [31:0] r_zr, n_zr;
    logic signed [31:0] r_zi, n_zi;
    logic        [11:0] r_count, n_count;
    logic               r_fresh, n_fresh;
    logic               r_inside, n_inside;
    logic        [23:0] r_offset, n_offset;
    logic signed [63:0] r_p0, r_p1, r_p2;

    // output registers
    logic               r_out_valid, n_out_valid;
    logic        [11:0] r_o_count;
    logic               r_o_inside;
    logic        [31:0] r_o_color;
    logic        [23:0] r_o_offset;

    // combinational helpers
    logic               w_cfg_wr;
    logic               w_in_acc;
    logic               w_out_load;
    logic        [11:0] w_limit;
    logic        [11:0] w_count_inc;
    logic        [15:0] w_count_x10;
    logic signed [32:0] w_ma0, w_mb0, w_ma1, w_mb1, w_ma2, w_mb2;
    logic signed [65:0] w_prod0, w_prod1, w_prod2;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_re_sh;
    logic signed [63:0] w_im_sh;
    logic signed [31:0] w_new_re;
    logic signed [31:0] w_new_im;
    logic signed [31:0] w_start_re;
    logic signed [31:0] w_start_im;
    logic        [63:0] w_mag;
    logic               w_escape;
    logic        [23:0] w_px_bytes;

    // configuration write and read
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_re    <= '0;
            r_const_im    <= '0;
            r_pixel_step  <= 31'd1048576;
            r_origin_re   <= -32'sd536870912;
            r_origin_im   <= -32'sd536870912;
            r_iter_limit  <= 12'd100;
            r_color_base  <= 32'd16777215;
            r_line_stride <= 15'd4096;
        end else if (w_cfg_wr) begin
            case (jetp_pkg::t_reg_idx'(paddr[4:2]))
                jetp_pkg::REG_CONST_RE:    r_const_re    <= pwdata[30:0];
                jetp_pkg::REG_CONST_IM:    r_const_im    <= pwdata[30:0];
                jetp_pkg::REG_PIXEL_STEP:  r_pixel_step  <= pwdata[30:0];
                jetp_pkg::REG_ORIGIN_RE:   r_origin_re   <= pwdata;
                jetp_pkg::REG_ORIGIN_IM:   r_origin_im   <= pwdata;
                jetp_pkg::REG_ITER_LIMIT:  r_iter_limit  <= pwdata[11:0];
                jetp_pkg::REG_COLOR_BASE:  r_color_base  <= pwdata;
                jetp_pkg::REG_LINE_STRIDE: r_line_stride <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (jetp_pkg::t_reg_idx'(paddr[4:2]))
            jetp_pkg::REG_CONST_RE:    prdata = {r_const_re[30], r_const_re};
            jetp_pkg::REG_CONST_IM:    prdata = {r_const_im[30], r_const_im};
            jetp_pkg::REG_PIXEL_STEP:  prdata = {1'b0, r_pixel_step};
            jetp_pkg::REG_ORIGIN_RE:   prdata = r_origin_re;
            jetp_pkg::REG_ORIGIN_IM:   prdata = r_origin_im;
            jetp_pkg::REG_ITER_LIMIT:  prdata = {20'd0, r_iter_limit};
            jetp_pkg::REG_COLOR_BASE:  prdata = r_color_base;
            jetp_pkg::REG_LINE_STRIDE: prdata = {17'd0, r_line_stride};
            default:                   prdata = '0;
        endcase
    end

    // handshakes
    assign o_in_stall = (r_state != jetp_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_load = (r_state == jetp_pkg::ST_RESULT) & (~r_out_valid | ~i_out_stall);

    // limit of zero behaves as one
    assign w_limit     = (r_iter_limit == '0) ? 12'd1 : r_iter_limit;
    assign w_count_inc = r_count + 12'd1;
    assign w_count_x10 = 16'({r_count, 3'b000}) + 16'({r_count, 1'b0});

    // operand selection for the shared multiplier unit
    always_comb begin
        case (r_state)
            jetp_pkg::ST_SETUP: begin
                w_ma0 = {23'd0, r_px};
                w_mb0 = {2'b00, r_pixel_step};
                w_ma1 = {23'd0, r_py};
                w_mb1 = {2'b00, r_pixel_step};
                w_ma2 = {23'd0, r_py};
                w_mb2 = {18'd0, r_line_stride};
            end
            // color product, held while the result word waits
            jetp_pkg::ST_COLOR, jetp_pkg::ST_RESULT: begin
                w_ma0 = {1'b0, r_color_base};
                w_mb0 = {17'd0, w_count_x10};
                w_ma1 = '0;
                w_mb1 = '0;
                w_ma2 = '0;
                w_mb2 = '0;
            end
            default: begin
                w_ma0 = 33'(r_zr);
                w_mb0 = 33'(r_zr);
                w_ma1 = 33'(r_zi);
                w_mb1 = 33'(r_zi);
                w_ma2 = 33'(r_zr);
                w_mb2 = 33'(r_zi);
            end
        endcase
    end

    assign w_prod0 = w_ma0 * w_mb0;
    assign w_prod1 = w_ma1 * w_mb1;
    assign w_prod2 = w_ma2 * w_mb2;

    // product registers
    always_ff @(posedge i_clk) begin
        r_p0 <= w_prod0[63:0];
        r_p1 <= w_prod1[63:0];
        r_p2 <= w_prod2[63:0];
    end

    // start point from pixel products
    assign w_start_re = jetp_pkg::sat32($signed(r_p0[43:0]) + 44'(r_origin_re));
    assign w_start_im = jetp_pkg::sat32($signed(r_p1[43:0]) + 44'(r_origin_im));
    assign w_px_bytes = 24'(r_px) * 24'(BYTES_PER_PIXEL);

    // z update from the squares, floor shifts then add c
    assign w_diff   = r_p0 - r_p1;
    assign w_re_sh  = w_diff >>> jetp_pkg::FRAC_BITS;
    assign w_im_sh  = r_p2 >>> (jetp_pkg::FRAC_BITS - 1);
    assign w_new_re = jetp_pkg::sat32($signed(w_re_sh[43:0]) + 44'(r_const_re));
    assign w_new_im = jetp_pkg::sat32($signed(w_im_sh[43:0]) + 44'(r_const_im));

    // escape test on the squares of the current z
    assign w_mag    = $unsigned(r_p0) + $unsigned(r_p1);
    assign w_escape = |w_mag[63:jetp_pkg::ESC_BIT];

    // sequencer: next state and datapath loads
    always_comb begin
        n_state  = r_state;
        n_px     = r_px;
        n_py     = r_py;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_count  = r_count;
        n_fresh  = r_fresh;
        n_inside = r_inside;
        n_offset = r_offset;
        case (r_state)
            jetp_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_px    = i_pixel_x;
                    n_py    = i_pixel_y;
                    n_state = jetp_pkg::ST_SETUP;
                end
            end
            jetp_pkg::ST_SETUP: begin
                n_state = jetp_pkg::ST_START;
            end
            jetp_pkg::ST_START: begin
                n_zr     = w_start_re;
                n_zi     = w_start_im;
                n_offset = r_p2[23:0] + w_px_bytes;
                n_count  = 12'd1;
                n_fresh  = 1'b0;
                if (w_limit == 12'd1) begin
                    n_inside = 1'b1;
                    n_state  = jetp_pkg::ST_COLOR;
                end else begin
                    n_state = jetp_pkg::ST_MUL;
                end
            end
            jetp_pkg::ST_MUL: begin
                n_state = jetp_pkg::ST_UPD;
            end
            jetp_pkg::ST_UPD: begin
                if (r_fresh && w_escape) begin
                    n_inside = 1'b0;
                    n_state  = jetp_pkg::ST_COLOR;
                end else if (r_fresh && (w_count_inc == w_limit)) begin
                    n_count  = w_count_inc;
                    n_inside = 1'b1;
                    n_state  = jetp_pkg::ST_COLOR;
                end else begin
                    n_zr    = w_new_re;
                    n_zi    = w_new_im;
                    n_fresh = 1'b1;
                    if (r_fresh) begin
                        n_count = w_count_inc;
                    end
                    n_state = jetp_pkg::ST_MUL;
                end
            end
            jetp_pkg::ST_COLOR: begin
                n_state = jetp_pkg::ST_RESULT;
            end
            jetp_pkg::ST_RESULT: begin
                if (w_out_load) begin
                    n_state = jetp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jetp_pkg::ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jetp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_fresh     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fresh     <= n_fresh;
        end
    end

    // datapath and result word registers
    always_ff @(posedge i_clk) begin
        r_px     <= n_px;
        r_py     <= n_py;
        r_zr     <= n_zr;
        r_zi     <= n_zi;
        r_count  <= n_count;
        r_inside <= n_inside;
        r_offset <= n_offset;
        if (w_out_load) begin
            r_o_count  <= r_count;
            r_o_inside <= r_inside;
            r_o_color  <= r_inside ? 32'd0 : r_p0[31:0];
            r_o_offset <= r_offset;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_o_count;
    assign o_inside_set      = r_o_inside;
    assign o_pixel_color     = r_o_color;
    assign o_byte_offset     = r_o_offset;

    // checks on the sequencer and result word
    `AST_IMP(a_count_below_limit, r_state == jetp_pkg::ST_UPD, r_count < w_limit, "count reached limit inside loop")
    `AST_NXT(a_result_loads, (r_state == jetp_pkg::ST_RESULT) && !r_out_valid, r_out_valid, "finished word not loaded into output register")
    `AST_IMP(a_inside_black, o_out_valid && o_inside_set, o_pixel_color == 32'd0, "inside pixel with nonzero color")
    `AST_IMP(a_inside_count, o_out_valid && o_inside_set, o_iteration_count == w_limit, "inside pixel count differs from limit")

endmodule

// ===== tb/sv/julia_pixel_checker.sv =====
`timescale 1ns / 100ps
// result checker for the julia escape-time pixel block: tracks the register file,
// predicts each pixel's escape result and compares it with the output channel
// depends on jetp_pkg for the register map and the fixed point format
module julia_pixel_checker #(
    parameter int BYTES_PER_PIXEL = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration port, observed only
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,

    // pixel channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,

    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [11:0] i_iteration_count,
    input  logic        i_inside_set,
    input  logic [31:0] i_pixel_color,
    input  logic [23:0] i_byte_offset,

    output int          o_pending,
    output int          o_error_count
);

    localparam logic [63:0] ESCAPE_BOUND = 64'd4 << jetp_pkg::FRAC_BITS;

    typedef struct packed {
        logic [11:0] count;
        logic        in_set;
        logic [31:0] color;
        logic [23:0] offset;
    } t_escape_result;

    // shadow copy of the register file
    longint      c_re;
    longint      c_im;
    longint      step_q;
    longint      origin_re;
    longint      origin_im;
    logic [11:0] limit_q;
    logic [63:0] color_base_q;
    logic [63:0] stride_q;

    t_escape_result results_due[$];
    t_escape_result want;
    int             error_total = 0;

    assign o_error_count = error_total;

    // clamp to the signed 32-bit word range
    function automatic longint clamp_word(input longint v);
        longint res;
        if (v > 64'sd2147483647) begin
            res = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            res = -64'sd2147483648;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // escape-time result of one pixel under the current registers
    function automatic t_escape_result escape_time_of(input logic [9:0] px,
                                                      input logic [9:0] py);
        longint         zr;
        longint         zi;
        longint         rr;
        longint         ii;
        longint         ri;
        logic [63:0]    sq_re;
        logic [63:0]    sq_im;
        logic [63:0]    sq_sum;
        logic [11:0]    lim;
        logic [11:0]    count;
        logic           escaped;
        logic [63:0]    shade;
        logic [63:0]    where;
        t_escape_result res;
        lim = (limit_q == 12'd0) ? 12'd1 : limit_q;
        zr = clamp_word(longint'({54'd0, px}) * step_q + origin_re);
        zi = clamp_word(longint'({54'd0, py}) * step_q + origin_im);
        count = 12'd1;
        escaped = 1'b0;
        while (count < lim && !escaped) begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            zr = clamp_word(((rr - ii) >>> jetp_pkg::FRAC_BITS) + c_re);
            zi = clamp_word((ri >>> (jetp_pkg::FRAC_BITS - 1)) + c_im);
            // exact magnitude test in unsigned 64 bits
            sq_re = zr * zr;
            sq_im = zi * zi;
            sq_sum = sq_re + sq_im;
            if ((sq_sum >> jetp_pkg::FRAC_BITS) >= ESCAPE_BOUND) begin
                escaped = 1'b1;
            end else begin
                count = count + 12'd1;
            end
        end
        shade = color_base_q * {52'd0, count} * 64'd10;
        where = {54'd0, py} * stride_q + {54'd0, px} * BYTES_PER_PIXEL;
        res.count = count;
        res.in_set = (count == lim);
        res.color = res.in_set ? 32'd0 : shade[31:0];
        res.offset = where[23:0];
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] expected_v,
                               input logic [31:0] actual_v);
        if (expected_v !== actual_v) begin
            if (error_total < 100) begin
                $display("%0t %s mismatch: expected %0h actual %0h",
                         $time, what, expected_v, actual_v);
            end
            error_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_re = 0;
            c_im = 0;
            step_q = 1048576;
            origin_re = -536870912;
            origin_im = -536870912;
            limit_q = 12'd100;
            color_base_q = 64'd16777215;
            stride_q = 64'd4096;
            results_due.delete();
            o_pending <= 0;
        end else begin
            // register writes, masked to each register's width
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (jetp_pkg::t_reg_idx'(i_paddr[4:2]))
                    jetp_pkg::REG_CONST_RE:
                        c_re = {{33{i_pwdata[30]}}, i_pwdata[30:0]};
                    jetp_pkg::REG_CONST_IM:
                        c_im = {{33{i_pwdata[30]}}, i_pwdata[30:0]};
                    jetp_pkg::REG_PIXEL_STEP:  step_q = {33'd0, i_pwdata[30:0]};
                    jetp_pkg::REG_ORIGIN_RE:   origin_re = {{32{i_pwdata[31]}}, i_pwdata};
                    jetp_pkg::REG_ORIGIN_IM:   origin_im = {{32{i_pwdata[31]}}, i_pwdata};
                    jetp_pkg::REG_ITER_LIMIT:  limit_q = i_pwdata[11:0];
                    jetp_pkg::REG_COLOR_BASE:  color_base_q = {32'd0, i_pwdata};
                    jetp_pkg::REG_LINE_STRIDE: stride_q = {49'd0, i_pwdata[14:0]};
                    default: ;
                endcase
            end
            // result word against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    if (error_total < 100) begin
                        $display("%0t unexpected result word: count %0d color %0h",
                                 $time, i_iteration_count, i_pixel_color);
                    end
                    error_total++;
                end else begin
                    want = results_due.pop_front();
                    check_field("iteration_count", want.count, i_iteration_count);
                    check_field("inside_set", want.in_set, i_inside_set);
                    check_field("pixel_color", want.color, i_pixel_color);
                    check_field("byte_offset", want.offset, i_byte_offset);
                end
            end
            // pixel word accepted, queue its prediction
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(escape_time_of(i_pixel_x, i_pixel_y));
            end
            o_pending <= results_due.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top of the julia escape-time pixel testbench: clock, reset, register setup,
// pixel stimulus with idle and stall phases, and the verdict
// depends on jetp_pkg, julia_escape_time_pixel and julia_pixel_checker
module testbench;

    localparam int PIXEL_BYTES   = 4;
    localparam int QUIET_LIMIT   = 40000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_PIXELS  = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [9:0]  pixel_x = '0;
    logic [9:0]  pixel_y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] iteration_count;
    logic        inside_set;
    logic [31:0] pixel_color;
    logic [23:0] byte_offset;

    int pending;
    int error_count;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    julia_escape_time_pixel #(
        .BYTES_PER_PIXEL(PIXEL_BYTES)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_pixel_x(pixel_x),
        .i_pixel_y(pixel_y),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_iteration_count(iteration_count),
        .o_inside_set(inside_set),
        .o_pixel_color(pixel_color),
        .o_byte_offset(byte_offset)
    );

    julia_pixel_checker #(
        .BYTES_PER_PIXEL(PIXEL_BYTES)
    ) checker_inst (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .i_pready(pready),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_pixel_x(pixel_x),
        .i_pixel_y(pixel_y),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_iteration_count(iteration_count),
        .i_inside_set(inside_set),
        .i_pixel_color(pixel_color),
        .i_byte_offset(byte_offset),
        .o_pending(pending),
        .o_error_count(error_count)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // one register write: setup cycle, then access cycle until pready
    task automatic write_reg(input jetp_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_window(input logic [31:0] c_re, input logic [31:0] c_im,
                                input logic [31:0] step, input logic [31:0] o_re,
                                input logic [31:0] o_im, input logic [31:0] limit,
                                input logic [31:0] color, input logic [31:0] stride);
        write_reg(jetp_pkg::REG_CONST_RE, c_re);
        write_reg(jetp_pkg::REG_CONST_IM, c_im);
        write_reg(jetp_pkg::REG_PIXEL_STEP, step);
        write_reg(jetp_pkg::REG_ORIGIN_RE, o_re);
        write_reg(jetp_pkg::REG_ORIGIN_IM, o_im);
        write_reg(jetp_pkg::REG_ITER_LIMIT, limit);
        write_reg(jetp_pkg::REG_COLOR_BASE, color);
        write_reg(jetp_pkg::REG_LINE_STRIDE, stride);
    endtask

    // one pixel word, with optional idle cycles ahead of it
    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        pixel_x = x;
        pixel_y = y;
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid and wait until every predicted result is out
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random view window: mostly a sane plane window, sometimes raw noise
    task automatic load_random_window(input bit wild);
        int step;
        int c_re;
        int c_im;
        int o_re;
        int o_im;
        int limit;
        step = $urandom_range(1 << 21, 1 << 19);
        if ($urandom_range(3) == 0) begin
            c_re = $urandom_range(1 << 30) - (1 << 29);
            c_im = $urandom_range(1 << 30) - (1 << 29);
        end else begin
            c_re = $urandom_range(1 << 29) - (1 << 28);
            c_im = $urandom_range(1 << 29) - (1 << 28);
        end
        o_re = -(step * 512) + $urandom_range(1 << 27) - (1 << 26);
        o_im = -(step * 512) + $urandom_range(1 << 27) - (1 << 26);
        limit = ($urandom_range(7) == 0) ? 1 : $urandom_range(150, 2);
        if (wild) begin
            write_window($urandom, $urandom, $urandom, $urandom, $urandom,
                         {20'($urandom), 12'($urandom_range(150))}, $urandom, $urandom);
        end else begin
            write_window(c_re, c_im, step, o_re, o_im, limit, $urandom,
                         $urandom_range(16384, 4));
        end
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: corners and the plane center
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        wait_idle();

        // limit of zero acts as one
        write_window(0, 0, 1 << 20, -(1 << 29), -(1 << 29), 0, 32'hFFFFFF, 4096);
        send_pixel(10'd700, 10'd300);
        wait_idle();
        // limit of one
        write_window(0, 0, 1 << 20, -(1 << 29), -(1 << 29), 1, 32'hFFFFFF, 4096);
        send_pixel(10'd3, 10'd5);
        wait_idle();

        // zero step at the origin: fixed point, runs the full maximum limit
        write_window(0, 0, 0, 0, 0, 4095, 32'h12345678, 4096);
        send_pixel(10'd0, 10'd0);
        wait_idle();
        // positive constant of 2.0 in both parts
        write_window(1 << 29, 1 << 29, 0, 0, 0, 4095, 32'h12345678, 4096);
        send_pixel(10'd77, 10'd88);
        wait_idle();

        // constant of -2.0 in both parts, widest stride with offset wrap, full color
        write_window(-(1 << 29), -(1 << 29), 1 << 20, 0, 0, 200, 32'hFFFFFFFF, 32767);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd1);
        wait_idle();

        // start point saturating high, smallest stride, zero color
        write_window(1 << 27, -(1 << 27), 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     50, 0, 4);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        wait_idle();
        // start point at the most negative word
        write_window(1 << 27, -(1 << 27), 0, 32'h80000000, 32'h80000000, 50, 7, 16384);
        send_pixel(10'd5, 10'd5);
        wait_idle();

        // classic dendrite-like constant, longer orbits
        write_window(-214748365, 41875931, 1 << 20, -(1 << 29), -(1 << 29), 300,
                     32'h00ABCDEF, 16384);
        send_pixel(10'd400, 10'd600);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd600, 10'd400);
        wait_idle();

        // random phases, each with its own window and idle pattern
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_random_window(phase % 5 == 4);
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 88;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                // sender holds off until the block has drained
                if (phase % 3 == 1 && n == PHASE_PIXELS / 2) begin
                    wait_idle();
                end
                send_pixel(10'($urandom), 10'($urandom));
            end
            wait_idle();
        end

        stall_pct = 0;
        repeat (20) @(negedge clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/jetp_pkg.sv
design/julia_escape_time_pixel.sv
tb/sv/julia_pixel_checker.sv
tb/sv/testbench.sv
